@@ design/nfpa_pkg.sv @@
// Shared types and constants of the NAND page array.
`timescale 1ns / 1ps
package nfpa_pkg;

	// Command codes of the func field
	typedef enum logic [2:0] {
		F_PROG  = 3'd0,
		F_READ  = 3'd1,
		F_ERASE = 3'd2,
		F_INVAL = 3'd3,
		F_STAT  = 3'd4
	} func_t;

	// Result status codes, also used as the error code of a program run
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_RANGE      = 2'd1,
		ST_PROGRAMMED = 2'd2,
		ST_LENGTH     = 2'd3
	} stat_t;

	// Configuration register indexes
	localparam logic REG_BLOCKS = 1'b0;
	localparam logic REG_PAGES  = 1'b1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = 2;

	localparam int ADDR_BITS = 4;
	localparam int CFG_BITS  = 5;
	localparam int WORD_BITS = 64;
	localparam int WEAR_BITS = 32;

	// Classified command as it travels through the queue
	typedef struct packed {
		func_t                  func;
		logic [ADDR_BITS-1:0]   blk;
		logic [ADDR_BITS-1:0]   pg;
		logic [WORD_BITS-1:0]   data;
		logic                   last;
		logic                   blk_ok;
		logic                   in_range;
	} cmd_t;

endpackage

@@ design/nand_flash_page_array.sv @@
// Top level of the NAND page array: configuration registers and front/queue/back.
`timescale 1ns / 1ps
// NAND array of MAX_BLOCKS blocks of MAX_PAGES pages, each page PAGE_WORDS
// 64-bit words, with program, read, erase, invalidate and status commands.
// Items enter a front end that drops unused command codes and range-checks
// the address, then wait in a four-item queue for the back end, which runs
// one command at a time. Program words are taken one per cycle, the last
// only when the result register is free; a run gives a single result on
// its last word. An in-range read uses the single registered read port of
// the page store: it fetches the first word, then returns one word per
// cycle unless the output stalls. The page store has no reset and needs
// no clearing pass; flags and wear counts clear at reset. Write the
// configuration registers only while idle.
module nand_flash_page_array #(
	parameter int MAX_BLOCKS = 16,
	parameter int MAX_PAGES  = 16,
	parameter int PAGE_WORDS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [nfpa_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     func,
	input  logic [nfpa_pkg::ADDR_BITS-1:0] block_index,
	input  logic [nfpa_pkg::ADDR_BITS-1:0] page_index,
	input  logic [nfpa_pkg::WORD_BITS-1:0] data_word,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [nfpa_pkg::WORD_BITS-1:0] read_word,
	output logic                           page_valid,
	output logic                           page_programmed,
	output logic [nfpa_pkg::WEAR_BITS-1:0] wear_count,
	output logic                           last_result
);
	import nfpa_pkg::*;

	logic [CFG_BITS-1:0] blocks_in_use_q;
	logic [CFG_BITS-1:0] pages_in_use_q;
	logic                q_full;
	logic                push;
	cmd_t                push_cmd;
	logic                head_valid;
	cmd_t                head;
	logic                pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= CFG_BITS'(16);
			pages_in_use_q  <= CFG_BITS'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCKS: blocks_in_use_q <= cfg_data;
				REG_PAGES:  pages_in_use_q  <= cfg_data;
			endcase
		end
	end

	assign in_stall = q_full;

	nfpa_front #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_PAGES (MAX_PAGES)
	) u_front (
		.in_valid     (in_valid),
		.q_full       (q_full),
		.func         (func),
		.block_index  (block_index),
		.page_index   (page_index),
		.data_word    (data_word),
		.last         (last),
		.blocks_in_use(blocks_in_use_q),
		.pages_in_use (pages_in_use_q),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	nfpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	nfpa_back #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_PAGES (MAX_PAGES),
		.PAGE_WORDS(PAGE_WORDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.read_word      (read_word),
		.page_valid     (page_valid),
		.page_programmed(page_programmed),
		.wear_count     (wear_count),
		.last_result    (last_result)
	);

endmodule

@@ design/nfpa_front.sv @@
// Front end: accepts items, drops unused codes and range-checks the address.
`timescale 1ns / 1ps
module nfpa_front #(
	parameter int MAX_BLOCKS = 16,
	parameter int MAX_PAGES  = 16
) (
	input  logic                          in_valid,
	input  logic                          q_full,
	input  logic [2:0]                    func,
	input  logic [nfpa_pkg::ADDR_BITS-1:0] block_index,
	input  logic [nfpa_pkg::ADDR_BITS-1:0] page_index,
	input  logic [nfpa_pkg::WORD_BITS-1:0] data_word,
	input  logic                          last,
	input  logic [nfpa_pkg::CFG_BITS-1:0]  blocks_in_use,
	input  logic [nfpa_pkg::CFG_BITS-1:0]  pages_in_use,
	output logic                          push,
	output nfpa_pkg::cmd_t                push_cmd
);
	import nfpa_pkg::*;

	logic known;
	logic blk_ok;
	logic pg_ok;

	// Only the five defined codes go on to the back end
	always_comb begin
		unique case (func)
			F_PROG, F_READ, F_ERASE, F_INVAL, F_STAT: known = 1'b1;
			default:                                  known = 1'b0;
		endcase
	end

	// In range: below both the register and the array size
	assign blk_ok = (CFG_BITS'(block_index) < blocks_in_use) &&
			(32'(block_index) < 32'(MAX_BLOCKS));
	assign pg_ok  = (CFG_BITS'(page_index) < pages_in_use) &&
			(32'(page_index) < 32'(MAX_PAGES));

	assign push = in_valid && !q_full && known;

	always_comb begin
		push_cmd.func     = func_t'(func);
		push_cmd.blk      = block_index;
		push_cmd.pg       = page_index;
		push_cmd.data     = data_word;
		push_cmd.last     = last;
		push_cmd.blk_ok   = blk_ok;
		push_cmd.in_range = blk_ok && pg_ok;
	end

endmodule

@@ design/nfpa_queue.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module nfpa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nfpa_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output nfpa_pkg::cmd_t head
);
	import nfpa_pkg::*;

	cmd_t                slots_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_PW:0]   cnt_q;

	assign full       = cnt_q == (QUEUE_PW+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slots_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ design/nfpa_back.sv @@
// Back end: page store, flag maps, wear counts, program runs and result register.
`timescale 1ns / 1ps
module nfpa_back #(
	parameter int MAX_BLOCKS = 16,
	parameter int MAX_PAGES  = 16,
	parameter int PAGE_WORDS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  nfpa_pkg::cmd_t                 head,
	output logic                           pop,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [1:0]                     status,
	output logic [nfpa_pkg::WORD_BITS-1:0] read_word,
	output logic                           page_valid,
	output logic                           page_programmed,
	output logic [nfpa_pkg::WEAR_BITS-1:0] wear_count,
	output logic                           last_result
);
	import nfpa_pkg::*;

	localparam int STORE_DEPTH = MAX_BLOCKS * MAX_PAGES * PAGE_WORDS;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int WW = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
	localparam int CW = $clog2(PAGE_WORDS + 2);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	// Storage
	logic [WORD_BITS-1:0] page_store_q [STORE_DEPTH];
	logic [MAX_PAGES-1:0] prog_map_q [MAX_BLOCKS];
	logic [MAX_PAGES-1:0] valid_map_q [MAX_BLOCKS];
	logic [WEAR_BITS-1:0] wear_q [MAX_BLOCKS];
	logic [WORD_BITS-1:0] rdata_q;

	// Sequencer and program run state
	state_t               state_q, state_d;
	logic [WW-1:0]        rd_w_q;
	logic                 run_active_q;
	logic [ADDR_BITS-1:0] run_blk_q;
	logic [ADDR_BITS-1:0] run_pg_q;
	logic                 run_blk_ok_q;
	logic                 run_in_q;
	logic [CW-1:0]        run_words_q;
	stat_t                run_err_q;

	// Result register
	logic                 out_valid_q;
	stat_t                out_status_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic                 out_pv_q;
	logic                 out_pp_q;
	logic [WEAR_BITS-1:0] out_wear_q;
	logic                 out_last_q;

	logic                 can_load;
	logic                 is_prog;
	logic                 run_start;
	logic [ADDR_BITS-1:0] a_blk;
	logic [ADDR_BITS-1:0] a_pg;
	logic                 a_blk_ok;
	logic                 a_in;
	logic [31:0]          a_blk_w;
	logic [31:0]          a_pg_w;
	logic [BW-1:0]        a_bi;
	logic [PW-1:0]        a_pi;
	logic                 cur_prog;
	logic                 cur_valid;
	logic [WEAR_BITS-1:0] cur_wear;
	stat_t                err_prev;
	stat_t                err_new;
	logic [CW-1:0]        words_prev;
	logic [CW-1:0]        words_new;
	logic [31:0]          base_w;
	logic [31:0]          wr_sum;
	logic [31:0]          rd_sum;

	logic                 load;
	stat_t                r_status;
	logic [WORD_BITS-1:0] r_word;
	logic                 r_pv;
	logic                 r_pp;
	logic [WEAR_BITS-1:0] r_wear;
	logic                 r_last;
	logic                 prog_step;
	logic                 prog_done;
	logic                 do_erase;
	logic                 do_inval;
	logic                 wr_en;
	logic                 rd_issue;
	logic [WW-1:0]        rd_addr_w;

	assign can_load  = !out_valid_q || !out_stall;
	assign is_prog   = head.func == F_PROG;
	assign run_start = !run_active_q;

	// Address in use: the captured run address for program words, else the item's
	always_comb begin
		if (is_prog && run_active_q) begin
			a_blk    = run_blk_q;
			a_pg     = run_pg_q;
			a_blk_ok = run_blk_ok_q;
			a_in     = run_in_q;
		end else begin
			a_blk    = head.blk;
			a_pg     = head.pg;
			a_blk_ok = head.blk_ok;
			a_in     = head.in_range;
		end
	end

	assign a_blk_w   = 32'(a_blk);
	assign a_pg_w    = 32'(a_pg);
	assign a_bi      = a_blk_w[BW-1:0];
	assign a_pi      = a_pg_w[PW-1:0];
	assign cur_prog  = prog_map_q[a_bi][a_pi];
	assign cur_valid = valid_map_q[a_bi][a_pi];
	assign cur_wear  = wear_q[a_bi];

	// Store addresses: page base plus word offset
	assign base_w = (a_blk_w * 32'(MAX_PAGES) + a_pg_w) * 32'(PAGE_WORDS);
	assign wr_sum = base_w + 32'(words_prev);
	assign rd_sum = base_w + 32'(rd_addr_w);

	// Program run bookkeeping for the word at the head
	always_comb begin
		err_prev   = run_start ? ST_OK : run_err_q;
		words_prev = run_start ? '0 : run_words_q;
		if (!a_in)
			err_new = ST_RANGE;
		else if (cur_prog && err_prev == ST_OK)
			err_new = ST_PROGRAMMED;
		else
			err_new = err_prev;
		if (words_prev <= CW'(PAGE_WORDS))
			words_new = words_prev + 1'b1;
		else
			words_new = words_prev;
	end

	// Command execution
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		r_status  = ST_OK;
		r_word    = '0;
		r_pv      = a_in ? cur_valid : 1'b0;
		r_pp      = a_in ? cur_prog : 1'b0;
		r_wear    = a_blk_ok ? cur_wear : '1;
		r_last    = 1'b1;
		prog_step = 1'b0;
		prog_done = 1'b0;
		do_erase  = 1'b0;
		do_inval  = 1'b0;
		rd_issue  = 1'b0;
		rd_addr_w = '0;
		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					unique case (head.func)
						F_PROG: begin
							if (!head.last) begin
								pop       = 1'b1;
								prog_step = 1'b1;
							end else if (can_load) begin
								pop       = 1'b1;
								prog_step = 1'b1;
								load      = 1'b1;
								priority if (err_new == ST_RANGE)
									r_status = ST_RANGE;
								else if (words_new != CW'(PAGE_WORDS))
									r_status = ST_LENGTH;
								else if (err_new == ST_PROGRAMMED)
									r_status = ST_PROGRAMMED;
								else begin
									r_status  = ST_OK;
									prog_done = 1'b1;
									r_pv      = 1'b1;
									r_pp      = 1'b1;
								end
							end
						end
						F_READ: begin
							if (can_load) begin
								if (!a_in) begin
									pop      = 1'b1;
									load     = 1'b1;
									r_status = ST_RANGE;
								end else begin
									rd_issue = 1'b1;
									state_d  = S_READ;
								end
							end
						end
						F_ERASE: begin
							if (can_load) begin
								pop  = 1'b1;
								load = 1'b1;
								if (a_blk_ok) begin
									do_erase = 1'b1;
									r_pv     = 1'b0;
									r_pp     = 1'b0;
									r_wear   = cur_wear + 32'd1;
								end else begin
									r_status = ST_RANGE;
								end
							end
						end
						F_INVAL: begin
							if (can_load) begin
								pop  = 1'b1;
								load = 1'b1;
								if (a_in) begin
									do_inval = 1'b1;
									r_pv     = 1'b0;
								end else begin
									r_status = ST_RANGE;
								end
							end
						end
						F_STAT: begin
							if (can_load) begin
								pop      = 1'b1;
								load     = 1'b1;
								r_status = a_in ? ST_OK : ST_RANGE;
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			S_READ: begin
				if (can_load) begin
					load   = 1'b1;
					r_word = cur_prog ? rdata_q : '0;
					r_last = rd_w_q == WW'(PAGE_WORDS - 1);
					if (r_last) begin
						pop     = 1'b1;
						state_d = S_IDLE;
					end else begin
						rd_issue  = 1'b1;
						rd_addr_w = rd_w_q + 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign wr_en = prog_step && err_new == ST_OK && words_prev < CW'(PAGE_WORDS);

	// Page store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			page_store_q[wr_sum[AW-1:0]] <= head.data;
		if (rd_issue)
			rdata_q <= page_store_q[rd_sum[AW-1:0]];
	end

	// Flag maps and wear counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				prog_map_q[i]  <= '0;
				valid_map_q[i] <= '0;
				wear_q[i]      <= '0;
			end
		end else begin
			if (prog_done) begin
				prog_map_q[a_bi][a_pi]  <= 1'b1;
				valid_map_q[a_bi][a_pi] <= 1'b1;
			end
			if (do_erase) begin
				prog_map_q[a_bi]  <= '0;
				valid_map_q[a_bi] <= '0;
				wear_q[a_bi]      <= cur_wear + 32'd1;
			end
			if (do_inval)
				valid_map_q[a_bi][a_pi] <= 1'b0;
		end
	end

	// Sequencer and program run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_w_q       <= '0;
			run_active_q <= 1'b0;
			run_blk_q    <= '0;
			run_pg_q     <= '0;
			run_blk_ok_q <= 1'b0;
			run_in_q     <= 1'b0;
			run_words_q  <= '0;
			run_err_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			if (rd_issue)
				rd_w_q <= rd_addr_w;
			if (prog_step) begin
				run_active_q <= !head.last;
				run_blk_q    <= a_blk;
				run_pg_q     <= a_pg;
				run_blk_ok_q <= a_blk_ok;
				run_in_q     <= a_in;
				run_words_q  <= words_new;
				run_err_q    <= err_new;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= r_status;
			out_word_q   <= r_word;
			out_pv_q     <= r_pv;
			out_pp_q     <= r_pp;
			out_wear_q   <= r_wear;
			out_last_q   <= r_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign read_word       = out_word_q;
	assign page_valid      = out_pv_q;
	assign page_programmed = out_pp_q;
	assign wear_count      = out_wear_q;
	assign last_result     = out_last_q;

endmodule
